// ===== rtl/core/dds_sws_pkg.sv =====
// ----------------------------------------------------------------------------
// DDS setup word sequencer package
// Shared constants, command word codes and the queue entry type.
// ----------------------------------------------------------------------------
package dds_sws_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int FREQ_W     = 25;
  localparam int PHASE_W    = 14;
  localparam int TW_W       = 28;
  localparam int HALF_W     = 14;
  localparam int POS_W      = 4;

  localparam int MULT_W     = 23;
  localparam int PROD_W     = 48;
  localparam int PROD_SHIFT = 5;
  localparam int DVD_W      = 44;
  localparam int REM_W      = 14;
  localparam int DIGIT_W    = 4;
  localparam int DIV_STEPS  = DVD_W / DIGIT_W;
  localparam int CNT_W      = 4;

  localparam logic [MULT_W-1:0] TW_MULT    = 23'd5368709;
  localparam logic [REM_W:0]    TW_DIVISOR = 15'd15625;

  localparam logic [1:0] SEL_F0       = 2'd0;
  localparam logic [1:0] SEL_F1       = 2'd1;
  localparam logic [1:0] SEL_SKIP_MIN = 2'd2;

  localparam logic [1:0] MODE_SINE     = 2'd0;
  localparam logic [1:0] MODE_TRIANGLE = 2'd1;
  localparam logic [1:0] MODE_SQUARE   = 2'd2;

  localparam logic [15:0] WORD_RESET    = 16'h0100;
  localparam logic [15:0] WORD_EXIT     = 16'h2100;
  localparam logic [15:0] TAG_F0        = 16'h4000;
  localparam logic [15:0] TAG_F1        = 16'h8000;
  localparam logic [15:0] TAG_PHASE     = 16'hC000;
  localparam logic [15:0] WORD_F0_END   = 16'h2000;
  localparam logic [15:0] WORD_F1_END   = 16'h2800;
  localparam logic [15:0] WAVE_SINE_W   = 16'h2000;
  localparam logic [15:0] WAVE_TRI_W    = 16'h2002;
  localparam logic [15:0] WAVE_SQR_W    = 16'h2028;

  // Single-channel run positions.
  localparam logic [POS_W-1:0] S_RESET = 4'd0;
  localparam logic [POS_W-1:0] S_EXIT  = 4'd1;
  localparam logic [POS_W-1:0] S_LO    = 4'd2;
  localparam logic [POS_W-1:0] S_HI    = 4'd3;
  localparam logic [POS_W-1:0] S_PHASE = 4'd4;
  localparam logic [POS_W-1:0] S_FEND  = 4'd5;
  localparam logic [POS_W-1:0] S_WAVE  = 4'd6;

  // Dual-channel run positions.
  localparam logic [POS_W-1:0] D_RESET0 = 4'd0;
  localparam logic [POS_W-1:0] D_EXIT0  = 4'd1;
  localparam logic [POS_W-1:0] D_RESET1 = 4'd2;
  localparam logic [POS_W-1:0] D_EXIT1  = 4'd3;
  localparam logic [POS_W-1:0] D_LO0    = 4'd4;
  localparam logic [POS_W-1:0] D_HI0    = 4'd5;
  localparam logic [POS_W-1:0] D_PHASE1 = 4'd6;
  localparam logic [POS_W-1:0] D_LO1    = 4'd7;
  localparam logic [POS_W-1:0] D_HI1    = 4'd8;
  localparam logic [POS_W-1:0] D_WAVE0  = 4'd9;
  localparam logic [POS_W-1:0] D_WAVE1  = 4'd10;

  typedef struct packed {
    logic                cmd;
    logic                chan;
    logic                has_freq;
    logic                sel_f1;
    logic [POS_W-1:0]    final_pos;
    logic [15:0]         wave_word;
    logic [PHASE_W-1:0]  phase;
    logic [TW_W-1:0]     tw;
  } sws_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sws_qstat_t;

endpackage

// ===== rtl/core/dds_sws_front.sv =====
// ----------------------------------------------------------------------------
// DDS setup word sequencer front end
// Accepts requests, derives the tuning word with a radix-16 divider and
// classifies the run before handing it to the queue.
// ----------------------------------------------------------------------------
module dds_sws_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dds_sws_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                              in_tuser,
  input  dds_sws_pkg::sws_qstat_t           q_stat,
  output logic                              q_push,
  output dds_sws_pkg::sws_entry_t           q_entry
);
  import dds_sws_pkg::*;

  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    dvd_r;
  logic [REM_W-1:0]    rem_r;
  logic [TW_W-1:0]     quo_r;
  logic                cmd_r;
  logic [1:0]          sel_r;
  logic [1:0]          mode_r;
  logic [PHASE_W-1:0]  phase_r;
  logic                chan_r;

  logic                accept;
  logic                last_step;
  logic                step_en;
  logic [PROD_W-1:0]   prod;
  logic [REM_W-1:0]    rem_step;
  logic [DIGIT_W-1:0]  qdig;
  logic                has_freq;
  logic                has_wave;
  logic [15:0]         wave_word;
  logic [POS_W-1:0]    final_pos;

  assign last_step = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign q_push    = busy_r && last_step && !q_stat.full;
  assign step_en   = busy_r && !(last_step && q_stat.full);
  assign in_tready = !busy_r || q_push;
  assign accept    = in_tvalid && in_tready;

  assign prod = PROD_W'(in_tdata[FREQ_W-1:0]) * PROD_W'(TW_MULT);

  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r    = rem_r;
    qdig = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {r, dvd_r[DVD_W-1-i]};
      if (t >= TW_DIVISOR) begin
        r = REM_W'(t - TW_DIVISOR);
        qdig[DIGIT_W-1-i] = 1'b1;
      end else begin
        r = t[REM_W-1:0];
      end
    end
    rem_step = r;
  end

  always_comb begin
    has_freq = (sel_r < SEL_SKIP_MIN);
    has_wave = 1'b1;
    case (mode_r)
      MODE_SINE:     wave_word = WAVE_SINE_W;
      MODE_TRIANGLE: wave_word = WAVE_TRI_W;
      MODE_SQUARE:   wave_word = WAVE_SQR_W;
      default: begin
        wave_word = WAVE_SINE_W;
        has_wave  = 1'b0;
      end
    endcase
    if (cmd_r) begin
      final_pos = has_wave ? D_WAVE1 : (has_freq ? D_HI1 : D_EXIT1);
    end else begin
      final_pos = has_wave ? S_WAVE : (has_freq ? S_FEND : S_EXIT);
    end
  end

  always_comb begin
    q_entry.cmd       = cmd_r;
    q_entry.chan      = chan_r;
    q_entry.has_freq  = has_freq;
    q_entry.sel_f1    = (sel_r == SEL_F1);
    q_entry.final_pos = final_pos;
    q_entry.wave_word = wave_word;
    q_entry.phase     = phase_r;
    q_entry.tw        = {quo_r[TW_W-DIGIT_W-1:0], qdig};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (q_push) begin
      busy_nxt = 1'b0;
    end else if (step_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd_r   <= DVD_W'(prod[PROD_W-1:PROD_SHIFT]);
      rem_r   <= '0;
      quo_r   <= '0;
      cmd_r   <= in_tuser;
      sel_r   <= in_tdata[26:25];
      mode_r  <= in_tdata[28:27];
      phase_r <= in_tdata[42:29];
      chan_r  <= in_tdata[43];
    end else if (step_en) begin
      dvd_r <= {dvd_r[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_r <= rem_step;
      quo_r <= {quo_r[TW_W-DIGIT_W-1:0], qdig};
    end
  end

endmodule

// ===== rtl/core/dds_sws_queue.sv =====
// ----------------------------------------------------------------------------
// DDS setup word sequencer queue
// Short first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
module dds_sws_queue #(
  parameter int DEPTH = dds_sws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  dds_sws_pkg::sws_entry_t push_entry,
  input  logic                    pop,
  output dds_sws_pkg::sws_entry_t pop_entry,
  output dds_sws_pkg::sws_qstat_t stat
);
  import dds_sws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  sws_entry_t         mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count_r == CNT_QW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_entry  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/dds_sws_back.sv =====
// ----------------------------------------------------------------------------
// DDS setup word sequencer back end
// Walks the run of one classified request and drives one command word per
// cycle through the output register while out_tready allows.
// ----------------------------------------------------------------------------
module dds_sws_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dds_sws_pkg::sws_qstat_t            q_stat,
  input  dds_sws_pkg::sws_entry_t            q_entry,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dds_sws_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import dds_sws_pkg::*;

  sws_entry_t          cur_r;
  logic                cur_vld_r, cur_vld_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                out_vld_r;
  logic [15:0]         word_r;
  logic                chan_r;
  logic                last_r;

  logic                load_ok;
  logic                emit;
  logic                is_last;
  logic                done;
  logic                take;
  logic [15:0]         word;
  logic                chan;
  logic [15:0]         tag;
  logic [15:0]         lo_w;
  logic [15:0]         hi_w;
  logic [15:0]         ph_w;
  logic [POS_W-1:0]    skip_from;
  logic [POS_W-1:0]    wave_start;

  assign load_ok = !out_vld_r || out_tready;
  assign emit    = cur_vld_r && load_ok;
  assign is_last = (pos_r == cur_r.final_pos);
  assign done    = emit && is_last;
  assign take    = !q_stat.empty && (!cur_vld_r || done);
  assign q_pop   = take;

  assign tag  = cur_r.sel_f1 ? TAG_F1 : TAG_F0;
  assign lo_w = {2'b00, cur_r.tw[HALF_W-1:0]} | tag;
  assign hi_w = {2'b00, cur_r.tw[TW_W-1:HALF_W]} | tag;
  assign ph_w = {2'b00, cur_r.phase} | TAG_PHASE;

  assign skip_from  = cur_r.cmd ? D_EXIT1 : S_EXIT;
  assign wave_start = cur_r.cmd ? D_WAVE0 : S_WAVE;

  always_comb begin
    word = WORD_RESET;
    chan = cur_r.chan;
    if (cur_r.cmd) begin
      case (pos_r)
        D_RESET0: begin word = WORD_RESET;      chan = 1'b0; end
        D_EXIT0:  begin word = WORD_EXIT;       chan = 1'b0; end
        D_RESET1: begin word = WORD_RESET;      chan = 1'b1; end
        D_EXIT1:  begin word = WORD_EXIT;       chan = 1'b1; end
        D_LO0:    begin word = lo_w;            chan = 1'b0; end
        D_HI0:    begin word = hi_w;            chan = 1'b0; end
        D_PHASE1: begin word = ph_w;            chan = 1'b1; end
        D_LO1:    begin word = lo_w;            chan = 1'b1; end
        D_HI1:    begin word = hi_w;            chan = 1'b1; end
        D_WAVE0:  begin word = cur_r.wave_word; chan = 1'b0; end
        D_WAVE1:  begin word = cur_r.wave_word; chan = 1'b1; end
        default:  begin word = WORD_RESET;      chan = 1'b0; end
      endcase
    end else begin
      case (pos_r)
        S_RESET: word = WORD_RESET;
        S_EXIT:  word = WORD_EXIT;
        S_LO:    word = lo_w;
        S_HI:    word = hi_w;
        S_PHASE: word = ph_w;
        S_FEND:  word = cur_r.sel_f1 ? WORD_F1_END : WORD_F0_END;
        S_WAVE:  word = cur_r.wave_word;
        default: word = WORD_RESET;
      endcase
    end
  end

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    pos_nxt     = pos_r;
    if (take) begin
      cur_vld_nxt = 1'b1;
      pos_nxt     = '0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
    end else if (emit) begin
      pos_nxt = (!cur_r.has_freq && pos_r == skip_from) ? wave_start
                                                        : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      pos_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      pos_r     <= pos_nxt;
      if (load_ok) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_entry;
    end
    if (emit) begin
      word_r <= word;
      chan_r <= chan;
      last_r <= is_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = word_r;
  assign out_tuser  = chan_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/core/dds_setup_word_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// DDS setup word sequencer
// Turns one waveform request into the run of 16-bit DDS command words.
//
//   Channel  Direction  tdata                          tuser         tlast
//   in_      slave      request fields                 cmd           -
//   out_     master     command_word                   word_channel  last_word
//
// The front end derives each tuning word in its radix-16 divider and accepts
// the next request in the cycle it hands one to the queue. The back end sends
// one word per cycle while out_tready allows, 2 to 11 words per request, and
// the divider works on the next request while a run is sent. Reset clears
// the handshake, step counter, run position and queue state only.
// A low out_tready with out_tvalid high holds the output register; the queue
// then fills and the divider holds its last step until there is room.
// ----------------------------------------------------------------------------
module dds_setup_word_sequencer_top #(
  parameter int QUEUE_DEPTH = dds_sws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // freq_hz[24:0], freq_reg_select[26:25], wave_mode[28:27],
  // phase_word[42:29], target_channel[43], zero[47:44]
  input  logic [dds_sws_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // command_word[15:0]
  output logic [dds_sws_pkg::OUT_DATA_W-1:0] out_tdata,
  // word_channel
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import dds_sws_pkg::*;

  sws_entry_t push_entry;
  sws_entry_t pop_entry;
  sws_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  dds_sws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  dds_sws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  dds_sws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("Front end pushed into a full queue.");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("Back end popped an empty queue.");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_stat.empty && !q_pop) |=> !q_stat.empty)
    else $error("Pushed request did not reach the queue.");

endmodule
